>>> hw/rtl/srp_pkg.sv
// Shared types, constants and helpers for the S-record S1/S9 parser.
package srp_pkg;

   localparam int unsigned ADDR_BITS = 16;
   localparam int unsigned SIZE_BITS = ADDR_BITS + 1;
   localparam int unsigned CHAR_BITS = 8;
   localparam int unsigned KIND_BITS = 3;
   localparam int unsigned RECORDS_BITS = 16;
   localparam int unsigned BYTES_BITS = 24;

   localparam logic [SIZE_BITS-1:0] IMAGE_SIZE_RESET = SIZE_BITS'(8192);

   // Characters that steer the parser.
   localparam logic [CHAR_BITS-1:0] CHAR_S = 8'h53;
   localparam logic [CHAR_BITS-1:0] CHAR_TYPE_DATA = 8'h31;
   localparam logic [CHAR_BITS-1:0] CHAR_TYPE_END = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_BITS-1:0] HEX_ALPHA_OFFSET = CHAR_UPPER_A - 8'd10;

   // Overhead bytes in the count field: two address bytes and the checksum.
   localparam logic [7:0] COUNT_OVERHEAD = 8'd3;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_WRITE     = 3'd0,
      KIND_DONE      = 3'd1,
      KIND_BAD_TYPE  = 3'd2,
      KIND_NOT_HEX   = 3'd3,
      KIND_SMALL_CNT = 3'd4
   } kind_type;

   typedef struct packed {
      logic                    valid;
      kind_type                kind;
      logic [ADDR_BITS-1:0]    write_address;
      logic [7:0]              write_data;
      logic                    beyond_size;
      logic [RECORDS_BITS-1:0] records_seen;
      logic [BYTES_BITS-1:0]   bytes_written;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nibble;
   } hex_type;

   // Uppercase hex only; lowercase letters are not digits here.
   function automatic hex_type hex_decode(input logic [CHAR_BITS-1:0] c);
      hex_type      h;
      logic [7:0]   diff;
      h    = '0;
      diff = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff     = c - CHAR_ZERO;
         h.ok     = 1'b1;
         h.nibble = diff[3:0];
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         diff     = c - HEX_ALPHA_OFFSET;
         h.ok     = 1'b1;
         h.nibble = diff[3:0];
      end
      return h;
   endfunction

endpackage

>>> hw/rtl/srp_channels.sv
// Valid/ready channel interfaces for the parser's character input and results.
interface srp_req_if;
   logic                          valid;
   logic                          ready;
   logic [srp_pkg::CHAR_BITS-1:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink (input valid, input in_char, output ready);
endinterface

interface srp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [srp_pkg::KIND_BITS-1:0]    kind;
   logic [srp_pkg::ADDR_BITS-1:0]    write_address;
   logic [7:0]                       write_data;
   logic                             beyond_size;
   logic [srp_pkg::RECORDS_BITS-1:0] records_seen;
   logic [srp_pkg::BYTES_BITS-1:0]   bytes_written;

   modport source (output valid, output kind, output write_address, output write_data,
                   output beyond_size, output records_seen, output bytes_written,
                   input ready);
   modport sink (input valid, input kind, input write_address, input write_data,
                 input beyond_size, input records_seen, input bytes_written,
                 output ready);
endinterface

>>> hw/rtl/srecord_s1_parser.sv
// Top level of the S1/S9 S-record parser: input word register, parser, result register.
//
// The parser takes one ASCII character per word on the req channel and
// gives at most one result word on the rsp channel: a write of one data
// byte with its address, a done on an S9 record, or an error (illegal
// record type, non-hex digit, count below three). After done or an error
// other than a short count the block halts and drops every further word
// until reset. One word is accepted in every cycle while results are
// taken. The accepted word is registered first; the parser then makes
// the whole state update for it in one step and loads its result into
// the result register, unless a full result register that is not
// being emptied holds the word back.
// A stalled rsp side holds one result in the output register and one
// character in the input register before req_chan.ready drops. The
// image_size register is written through csr_write_en and
// csr_write_data; it resets to 8192 and should only be changed while no
// word is in flight.
module srecord_s1_parser (
   input  logic                          clock,
   input  logic                          reset,
   srp_req_if.sink                       req_chan,
   srp_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_en,
   input  logic [srp_pkg::SIZE_BITS-1:0] csr_write_data
);

   // Input word register.
   logic                          in_valid_ff, in_valid_in;
   logic [srp_pkg::CHAR_BITS-1:0] in_char_ff;

   // Result register.
   logic                          out_valid_ff, out_valid_in;
   srp_pkg::result_type           out_data_ff;

   logic [srp_pkg::SIZE_BITS-1:0] image_size_ff;

   srp_pkg::result_type           result;
   logic                          advance;
   logic                          req_take;

   // The parser consumes the held character when the result register is
   // free or is being emptied in this same cycle.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = result.valid;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   srp_parse_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .in_char    (in_char_ff),
      .image_size (image_size_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         image_size_ff <= srp_pkg::IMAGE_SIZE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_en) image_size_ff <= csr_write_data;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) in_char_ff <= req_chan.in_char;
      if (advance && result.valid) out_data_ff <= result;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_data_ff.kind;
   assign rsp_chan.write_address = out_data_ff.write_address;
   assign rsp_chan.write_data    = out_data_ff.write_data;
   assign rsp_chan.beyond_size   = out_data_ff.beyond_size;
   assign rsp_chan.records_seen  = out_data_ff.records_seen;
   assign rsp_chan.bytes_written = out_data_ff.bytes_written;

endmodule

>>> hw/rtl/srp_parse_core.sv
// Record parsing state machine: one character per step, at most one result.
module srp_parse_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [srp_pkg::CHAR_BITS-1:0]     in_char,
   input  logic [srp_pkg::SIZE_BITS-1:0]     image_size,
   output srp_pkg::result_type               result
);

   typedef enum logic [3:0] {
      PH_HUNT, PH_TYPE, PH_CNT_HI, PH_CNT_LO,
      PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3,
      PH_DATA_HI, PH_DATA_LO, PH_CK1, PH_CK2, PH_HALT
   } phase_type;

   phase_type                           phase_ff, phase_in;
   logic [7:0]                          bytes_left_ff, bytes_left_in;
   logic [srp_pkg::ADDR_BITS-1:0]       cur_address_ff, cur_address_in;
   logic [3:0]                          high_nibble_ff, high_nibble_in;
   logic                                warn_flag_ff, warn_flag_in;
   logic [srp_pkg::RECORDS_BITS-1:0]    record_count_ff, record_count_in;
   logic [srp_pkg::BYTES_BITS-1:0]      byte_count_ff, byte_count_in;

   srp_pkg::hex_type                    hex;
   logic                                hex_phase;
   logic [7:0]                          count_value;
   logic [7:0]                          bytes_left_dec;
   logic [srp_pkg::ADDR_BITS-1:0]       addr_full;

   always_comb begin
      hex            = srp_pkg::hex_decode(in_char);
      hex_phase      = (phase_ff == PH_CNT_HI) || (phase_ff == PH_CNT_LO) ||
                       (phase_ff == PH_ADDR0) || (phase_ff == PH_ADDR1) ||
                       (phase_ff == PH_ADDR2) || (phase_ff == PH_ADDR3) ||
                       (phase_ff == PH_DATA_HI) || (phase_ff == PH_DATA_LO);
      count_value    = {high_nibble_ff, hex.nibble};
      bytes_left_dec = bytes_left_ff - 8'd1;
      addr_full      = {cur_address_ff[srp_pkg::ADDR_BITS-5:0], hex.nibble};

      phase_in        = phase_ff;
      bytes_left_in   = bytes_left_ff;
      cur_address_in  = cur_address_ff;
      high_nibble_in  = high_nibble_ff;
      warn_flag_in    = warn_flag_ff;
      record_count_in = record_count_ff;
      byte_count_in   = byte_count_ff;

      result               = '0;
      result.kind          = srp_pkg::KIND_WRITE;

      if (hex_phase && !hex.ok) begin
         phase_in    = PH_HALT;
         result.valid = 1'b1;
         result.kind  = srp_pkg::KIND_NOT_HEX;
      end else begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (in_char == srp_pkg::CHAR_S) phase_in = PH_TYPE;
            end
            PH_TYPE: begin
               if (in_char == srp_pkg::CHAR_TYPE_END) begin
                  phase_in     = PH_HALT;
                  result.valid = 1'b1;
                  result.kind  = srp_pkg::KIND_DONE;
               end else if (in_char != srp_pkg::CHAR_TYPE_DATA) begin
                  phase_in     = PH_HALT;
                  result.valid = 1'b1;
                  result.kind  = srp_pkg::KIND_BAD_TYPE;
               end else begin
                  phase_in = PH_CNT_HI;
               end
            end
            PH_CNT_HI: begin
               high_nibble_in = hex.nibble;
               phase_in       = PH_CNT_LO;
            end
            PH_CNT_LO: begin
               phase_in = PH_ADDR0;
               if (count_value < srp_pkg::COUNT_OVERHEAD) begin
                  // Too short for an address and checksum; parse on with no data bytes.
                  bytes_left_in = '0;
                  result.valid  = 1'b1;
                  result.kind   = srp_pkg::KIND_SMALL_CNT;
               end else begin
                  bytes_left_in = count_value - srp_pkg::COUNT_OVERHEAD;
               end
            end
            PH_ADDR0: begin
               cur_address_in = {{(srp_pkg::ADDR_BITS-4){1'b0}}, hex.nibble};
               phase_in       = PH_ADDR1;
            end
            PH_ADDR1: begin
               cur_address_in = addr_full;
               phase_in       = PH_ADDR2;
            end
            PH_ADDR2: begin
               cur_address_in = addr_full;
               phase_in       = PH_ADDR3;
            end
            PH_ADDR3: begin
               cur_address_in = addr_full;
               warn_flag_in   = ({1'b0, addr_full} > image_size);
               phase_in       = (bytes_left_ff == '0) ? PH_CK1 : PH_DATA_HI;
            end
            PH_DATA_HI: begin
               high_nibble_in = hex.nibble;
               phase_in       = PH_DATA_LO;
            end
            PH_DATA_LO: begin
               cur_address_in = cur_address_ff + 16'd1;
               if (byte_count_ff != '1) byte_count_in = byte_count_ff + 24'd1;
               bytes_left_in        = bytes_left_dec;
               phase_in             = (bytes_left_dec == '0) ? PH_CK1 : PH_DATA_HI;
               result.valid         = 1'b1;
               result.kind          = srp_pkg::KIND_WRITE;
               result.write_address = cur_address_ff;
               result.write_data    = {high_nibble_ff, hex.nibble};
               result.beyond_size   = warn_flag_ff;
            end
            PH_CK1: begin
               phase_in = PH_CK2;
            end
            PH_CK2: begin
               if (record_count_ff != '1) record_count_in = record_count_ff + 16'd1;
               phase_in = PH_HUNT;
            end
            PH_HALT: begin
               phase_in = PH_HALT;
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase
      end

      result.records_seen  = record_count_in;
      result.bytes_written = byte_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         bytes_left_ff   <= '0;
         cur_address_ff  <= '0;
         high_nibble_ff  <= '0;
         warn_flag_ff    <= 1'b0;
         record_count_ff <= '0;
         byte_count_ff   <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         cur_address_ff  <= cur_address_in;
         high_nibble_ff  <= high_nibble_in;
         warn_flag_ff    <= warn_flag_in;
         record_count_ff <= record_count_in;
         byte_count_ff   <= byte_count_in;
      end
   end

endmodule

>>> tb/sv/srecord_s1_parser_tb.sv
// Self-checking testbench for the S1/S9 S-record parser: character stream in, write results out.
module srecord_s1_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Record characters sent by the random part, not counting the noise
   // between records, which the parser only hunts through.
   localparam int RANDOM_WORDS = 1050;
   // A character's result reaches the result register once the parser
   // consumes it from the input register. The settle wait covers words
   // that give no result but are in flight when the last result shows up.
   localparam int SETTLE_CYCLES = 6;
   // Long receiver hold-off used to back the parser up into its input.
   localparam int HOLD_OFF_CYCLES = 400;

   // Phase of the parser as the testbench tracks it, one step per character.
   typedef enum logic [3:0] {
      SCAN_HUNT,
      SCAN_TYPE,
      SCAN_COUNT_HI,
      SCAN_COUNT_LO,
      SCAN_ADDR_0,
      SCAN_ADDR_1,
      SCAN_ADDR_2,
      SCAN_ADDR_3,
      SCAN_DATA_HI,
      SCAN_DATA_LO,
      SCAN_SUM_1,
      SCAN_SUM_2,
      SCAN_HALTED
   } scan_phase_type;

   // The three ways the stream can be brought to a halt at the end of the run.
   typedef enum int {
      STOP_BY_S9,
      STOP_BY_BAD_TYPE,
      STOP_BY_NOT_HEX
   } stream_stop_type;

   typedef struct {
      srp_pkg::kind_type                kind;
      logic [srp_pkg::ADDR_BITS-1:0]    address;
      logic [7:0]                       data;
      logic                             beyond;
      logic [srp_pkg::RECORDS_BITS-1:0] records;
      logic [srp_pkg::BYTES_BITS-1:0]   bytes;
   } parser_result_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_write_en;
   logic [srp_pkg::SIZE_BITS-1:0] csr_write_data;

   srp_req_if req_bus ();
   srp_rsp_if rsp_bus ();

   srecord_s1_parser i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Parser state as predicted by the testbench, plus its copy of the
   // image_size register.
   scan_phase_type                   scan_phase;
   logic [7:0]                       left_bytes;
   logic [srp_pkg::ADDR_BITS-1:0]    next_address;
   logic [3:0]                       upper_nibble;
   logic                             past_image;
   logic [srp_pkg::RECORDS_BITS-1:0] record_total;
   logic [srp_pkg::BYTES_BITS-1:0]   byte_total;
   logic [srp_pkg::SIZE_BITS-1:0]    image_limit;

   // Results the parser still owes, oldest first.
   parser_result_type expected_results[$];

   int    failures;
   int    words_accepted;
   int    noise_words;
   int    results_checked;
   int    size_writes;
   int    kind_tally[5];
   string stop_reason;

   // Sender burst bookkeeping and the receiver hold-off request.
   int burst_left;
   int hold_request;

   // The clock runs free for the whole run.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard ceiling on the run. A correct run needs only a fraction of this
   // even with every gap and stall at its longest.
   initial begin
      #(4_000_000);
      $display("srecord_s1_parser regression: fail");
      $finish;
   end

   // Decodes an uppercase hex digit; anything else, lowercase letters
   // included, gives -1.
   function automatic int nibble_of(input logic [srp_pkg::CHAR_BITS-1:0] c);
      if (c >= srp_pkg::CHAR_ZERO && c <= srp_pkg::CHAR_NINE) begin
         return int'(c - srp_pkg::CHAR_ZERO);
      end
      if (c >= srp_pkg::CHAR_UPPER_A && c <= srp_pkg::CHAR_UPPER_F) begin
         return int'(c - srp_pkg::CHAR_UPPER_A) + 10;
      end
      return -1;
   endfunction

   function automatic logic [srp_pkg::CHAR_BITS-1:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? 8'(srp_pkg::CHAR_ZERO + n)
                         : 8'(srp_pkg::CHAR_UPPER_A + n - 8'd10);
   endfunction

   // Queues one expected result. The running totals are taken as they
   // stand at the moment the result is produced.
   function automatic void push_result(input srp_pkg::kind_type k,
                                       input logic [srp_pkg::ADDR_BITS-1:0] a,
                                       input logic [7:0] d, input logic b);
      parser_result_type r;
      r.kind    = k;
      r.address = a;
      r.data    = d;
      r.beyond  = b;
      r.records = record_total;
      r.bytes   = byte_total;
      expected_results.push_back(r);
      kind_tally[k]++;
   endfunction

   // Advances the predicted parser by one accepted character and queues the
   // result, if any, that the character produces.
   function automatic void advance_parser(input logic [srp_pkg::CHAR_BITS-1:0] c);
      int         nib;
      logic [3:0] nv;
      logic [7:0] count;
      nib = nibble_of(c);
      nv  = nib[3:0];
      case (scan_phase)
         SCAN_HUNT: begin
            if (c == srp_pkg::CHAR_S) scan_phase = SCAN_TYPE;
         end
         SCAN_TYPE: begin
            if (c == srp_pkg::CHAR_TYPE_END) begin
               scan_phase = SCAN_HALTED;
               push_result(srp_pkg::KIND_DONE, '0, '0, 1'b0);
            end else if (c == srp_pkg::CHAR_TYPE_DATA) begin
               scan_phase = SCAN_COUNT_HI;
            end else begin
               scan_phase = SCAN_HALTED;
               push_result(srp_pkg::KIND_BAD_TYPE, '0, '0, 1'b0);
            end
         end
         SCAN_HALTED: begin
         end
         SCAN_SUM_1: begin
            scan_phase = SCAN_SUM_2;
         end
         SCAN_SUM_2: begin
            // The checksum is never checked; the second character closes the record.
            if (record_total != '1) record_total++;
            scan_phase = SCAN_HUNT;
         end
         default: begin
            if (nib < 0) begin
               scan_phase = SCAN_HALTED;
               push_result(srp_pkg::KIND_NOT_HEX, '0, '0, 1'b0);
            end else begin
               case (scan_phase)
                  SCAN_COUNT_HI: begin
                     upper_nibble = nv;
                     scan_phase   = SCAN_COUNT_LO;
                  end
                  SCAN_COUNT_LO: begin
                     count      = {upper_nibble, nv};
                     scan_phase = SCAN_ADDR_0;
                     // A short count is reported, then the record goes on
                     // with no data bytes at all.
                     if (count < srp_pkg::COUNT_OVERHEAD) begin
                        left_bytes = '0;
                        push_result(srp_pkg::KIND_SMALL_CNT, '0, '0, 1'b0);
                     end else begin
                        left_bytes = count - srp_pkg::COUNT_OVERHEAD;
                     end
                  end
                  SCAN_ADDR_0: begin
                     next_address = srp_pkg::ADDR_BITS'(nv);
                     scan_phase   = SCAN_ADDR_1;
                  end
                  SCAN_ADDR_1, SCAN_ADDR_2: begin
                     next_address = {next_address[srp_pkg::ADDR_BITS-5:0], nv};
                     scan_phase   = (scan_phase == SCAN_ADDR_1) ? SCAN_ADDR_2 : SCAN_ADDR_3;
                  end
                  SCAN_ADDR_3: begin
                     next_address = {next_address[srp_pkg::ADDR_BITS-5:0], nv};
                     past_image   = ({1'b0, next_address} > image_limit);
                     scan_phase   = (left_bytes == 0) ? SCAN_SUM_1 : SCAN_DATA_HI;
                  end
                  SCAN_DATA_HI: begin
                     upper_nibble = nv;
                     scan_phase   = SCAN_DATA_LO;
                  end
                  SCAN_DATA_LO: begin
                     if (byte_total != '1) byte_total++;
                     push_result(srp_pkg::KIND_WRITE, next_address, {upper_nibble, nv},
                                 past_image);
                     // The address wraps at 16 bits by its own width.
                     next_address++;
                     left_bytes--;
                     scan_phase = (left_bytes == 0) ? SCAN_SUM_1 : SCAN_DATA_HI;
                  end
                  default: begin
                     scan_phase = SCAN_HALTED;
                  end
               endcase
            end
         end
      endcase
   endfunction

   task automatic compare_field(input string name, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         failures++;
      end
   endtask

   // Compares one accepted result word with the oldest expectation.
   task automatic check_result();
      parser_result_type want;
      results_checked++;
      if (expected_results.size() == 0) begin
         $display("%0t ns: result word with nothing expected, kind %0d address 0x%h data 0x%h",
                  $time, rsp_bus.kind, rsp_bus.write_address, rsp_bus.write_data);
         failures++;
         return;
      end
      want = expected_results.pop_front();
      compare_field("kind", want.kind, rsp_bus.kind);
      compare_field("write_address", want.address, rsp_bus.write_address);
      compare_field("write_data", want.data, rsp_bus.write_data);
      compare_field("beyond_size", want.beyond, rsp_bus.beyond_size);
      compare_field("records_seen", want.records, rsp_bus.records_seen);
      compare_field("bytes_written", want.bytes, rsp_bus.bytes_written);
   endtask

   // Receiver: checks every word taken on the result channel and drives
   // ready. Its stall pattern switches at random between no
   // stalls, light stalls, heavy stalls and a regular one-in-three stall.
   // A hold-off request parks ready low until its count runs out.
   initial begin
      int stall_mode;
      int mode_left;
      int hold_left;
      stall_mode = 0;
      mode_left  = 0;
      hold_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) check_result();
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ((mode_left % 3) != 0);
            endcase
         end
      end
   end

   // Offers one word and returns at the edge where it is taken. The sender
   // works in bursts; when a burst runs out, valid may drop for a random gap
   // before the next one, and about a quarter of bursts follow with no gap.
   // Valid stays high on return, so back-to-back calls stream without a bubble.
   task automatic send_word(input logic [srp_pkg::CHAR_BITS-1:0] c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid   <= 1'b1;
      req_bus.in_char <= c;
      do @(posedge clock); while (!req_bus.ready);
      advance_parser(c);
      words_accepted++;
   endtask

   task automatic send_hex_byte(input logic [7:0] value);
      send_word(hex_char(value[7:4]));
      send_word(hex_char(value[3:0]));
   endtask

   // Characters between records; 'S' is left out so that no record starts.
   task automatic send_noise(input int n);
      logic [srp_pkg::CHAR_BITS-1:0] c;
      repeat (n) begin
         do c = 8'($urandom_range(0, 255)); while (c == srp_pkg::CHAR_S);
         send_word(c);
         noise_words++;
      end
   endtask

   // Sends one S1 record. Data bytes are random, or with fill >= 0 they
   // alternate between fill and its complement. Checksum characters are
   // arbitrary bytes, since the parser skips them.
   task automatic send_s1_record(input logic [7:0] count,
                                 input logic [srp_pkg::ADDR_BITS-1:0] address,
                                 input int fill);
      logic [7:0] value;
      send_word(srp_pkg::CHAR_S);
      send_word(srp_pkg::CHAR_TYPE_DATA);
      send_hex_byte(count);
      send_hex_byte(address[15:8]);
      send_hex_byte(address[7:0]);
      for (int i = 3; i < count; i++) begin
         if (fill < 0) value = 8'($urandom_range(0, 255));
         else value = (i % 2 != 0) ? 8'(fill) : ~8'(fill);
         send_hex_byte(value);
      end
      send_word(8'($urandom_range(0, 255)));
      send_word(8'($urandom_range(0, 255)));
   endtask

   // Drops valid and waits until every expected result is in, then gives
   // words that produce no result time to clear the pipeline.
   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Must only be called with the parser idle.
   task automatic write_image_size(input logic [srp_pkg::SIZE_BITS-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      image_limit = value;
      size_writes++;
   endtask

   // Short counts 00 and 02 at the reset image size, framed by the extreme
   // characters 0x00 and 0xFF while hunting.
   task automatic test_short_count();
      send_noise(0);
      send_word(8'h00);
      send_word(8'hFF);
      noise_words += 2;
      send_s1_record(8'h00, 16'h0000, -1);
      send_s1_record(8'h02, 16'h2000, -1);
   endtask

   // A record at the top of the address space: the second byte wraps to
   // address 0, and the start address lies past the reset image size.
   task automatic test_address_wrap();
      send_s1_record(8'h05, 16'hFFFF, 8'hFF);
   endtask

   // Random records over several image sizes, the extremes among them. Most
   // records are short, a few are long, and their start addresses cluster
   // around the image size and the top of the address space.
   task automatic test_random_records();
      logic [srp_pkg::SIZE_BITS-1:0] sizes[7];
      logic [srp_pkg::SIZE_BITS-1:0] near;
      logic [7:0]                    count;
      logic [srp_pkg::ADDR_BITS-1:0] address;
      int                            pick;
      int                            start_words;
      sizes[0] = '0;
      sizes[1] = 17'd65536;
      sizes[2] = 17'd65535;
      sizes[3] = 17'd1;
      sizes[4] = 17'($urandom_range(0, 65536));
      sizes[5] = 17'($urandom_range(0, 65536));
      sizes[6] = srp_pkg::IMAGE_SIZE_RESET;
      start_words = words_accepted - noise_words;
      for (int p = 0; p < 7; p++) begin
         wait_until_idle();
         write_image_size(sizes[p]);
         while (words_accepted - noise_words - start_words < RANDOM_WORDS * (p + 1) / 7) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) count = 8'($urandom_range(0, 2));
            else if (pick < 10) count = 8'($urandom_range(40, 255));
            else count = 8'($urandom_range(3, 12));
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
               address = 16'hFFFF - 16'($urandom_range(0, 8));
            end else if (pick < 5) begin
               near    = image_limit + 17'($urandom_range(0, 2)) - 17'd1;
               address = near[srp_pkg::ADDR_BITS-1:0];
            end else begin
               address = 16'($urandom_range(0, 65535));
            end
            send_s1_record(count, address, -1);
            send_noise($urandom_range(0, 3));
         end
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering a data record, so the result and input registers fill and
   // the parser stops taking characters until the receiver resumes.
   task automatic test_backpressure();
      wait_until_idle();
      hold_request = HOLD_OFF_CYCLES;
      @(posedge clock);
      send_s1_record(8'd40, 16'($urandom_range(0, 65535)), -1);
      send_s1_record(8'd4, 16'($urandom_range(0, 65535)), -1);
   endtask

   // The stream can end only once per reset, so each run picks one way to
   // end it: an S9 record, an illegal record type, or a non-hex digit inside
   // an S1 header. Words sent afterward, a full record included, must be
   // dropped without a result.
   task automatic test_end_of_stream();
      stream_stop_type               how;
      logic [srp_pkg::CHAR_BITS-1:0] c;
      int                            good_digits;
      how = stream_stop_type'($urandom_range(0, 2));
      case (how)
         STOP_BY_S9: begin
            stop_reason = "an S9 record";
            send_word(srp_pkg::CHAR_S);
            send_word(srp_pkg::CHAR_TYPE_END);
         end
         STOP_BY_BAD_TYPE: begin
            stop_reason = "an illegal record type";
            do c = 8'($urandom_range(0, 255));
            while (c == srp_pkg::CHAR_TYPE_DATA || c == srp_pkg::CHAR_TYPE_END);
            send_word(srp_pkg::CHAR_S);
            send_word(c);
         end
         default: begin
            stop_reason = "a non-hex digit";
            send_word(srp_pkg::CHAR_S);
            send_word(srp_pkg::CHAR_TYPE_DATA);
            // At most five good digits, so the bad one always lands in the header.
            good_digits = $urandom_range(0, 5);
            repeat (good_digits) send_word(hex_char(4'($urandom_range(0, 15))));
            // Lowercase hex is half of the bad digits, since it looks the most legal.
            if ($urandom_range(0, 1) == 0) c = 8'h61 + 8'($urandom_range(0, 5));
            else do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
            send_word(c);
         end
      endcase
      repeat (20) send_word(8'($urandom_range(0, 255)));
      send_s1_record(8'h04, 16'h0010, -1);
   endtask

   // Main sequence: reset, directed cases, random records, back-pressure,
   // then the end of the stream and the verdict.
   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.in_char <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      scan_phase      = SCAN_HUNT;
      left_bytes      = '0;
      next_address    = '0;
      upper_nibble    = '0;
      past_image      = 1'b0;
      record_total    = '0;
      byte_total      = '0;
      image_limit     = srp_pkg::IMAGE_SIZE_RESET;
      failures        = 0;
      words_accepted  = 0;
      noise_words     = 0;
      results_checked = 0;
      size_writes     = 0;
      burst_left      = 0;
      hold_request    = 0;
      stop_reason     = "";
      foreach (kind_tally[k]) kind_tally[k] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_short_count();
      test_address_wrap();
      test_random_records();
      test_backpressure();
      test_end_of_stream();
      wait_until_idle();

      $display("Covered %0d words, %0d results: %0d writes over %0d records, %0d short counts,",
               words_accepted, results_checked, kind_tally[srp_pkg::KIND_WRITE], record_total,
               kind_tally[srp_pkg::KIND_SMALL_CNT]);
      $display("%0d image size settings, and a stream ended by %s.", size_writes, stop_reason);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("srecord_s1_parser regression: pass");
      end else begin
         $display("srecord_s1_parser regression: fail");
      end
      $finish;
   end

endmodule

>>> srecord_s1_parser.f
hw/rtl/srp_pkg.sv
hw/rtl/srp_channels.sv
hw/rtl/srp_parse_core.sv
hw/rtl/srecord_s1_parser.sv
tb/sv/srecord_s1_parser_tb.sv
